/* rtl/core/hashed_value_noise_2d_assert.svh */
// Assertion macros used by the checker file of the noise block.
`ifndef HASHED_VALUE_NOISE_2D_ASSERT_SVH
`define HASHED_VALUE_NOISE_2D_ASSERT_SVH

// Check cons in the same cycle as ante.
`define HVN_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hvn check failed");

// Check cons in the cycle after ante.
`define HVN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hvn check failed");

`endif

/* rtl/core/hvn_pkg.sv */
// Types, constants and multiply helpers of the hashed value noise block.
package hvn_pkg;

    localparam int COORD_W    = 16;
    localparam int SPREAD_W   = 17;
    localparam int FREQ_W     = 22;
    localparam int PROD_RAW_W = COORD_W + FREQ_W;
    localparam int FRAC_W     = 16;
    localparam int WGT_W      = 17;
    localparam int CORNER_W   = 24;
    localparam int ROW_W      = 40;
    localparam int FIN_W      = ROW_W + WGT_W;
    localparam int OUT_W      = 24;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int PIPE_DEPTH = 12;

    localparam logic [FREQ_W-1:0]   FREQ_BASE    = 22'd65536;
    localparam logic [FREQ_W-1:0]   FREQ_SLOPE   = 22'd31;
    localparam logic [WGT_W-1:0]    ONE_Q16      = 17'h10000;
    localparam logic [17:0]         SMOOTH_THREE = 18'd196608;
    localparam logic [OUT_W-1:0]    HALF_OUT     = 24'h800000;

    localparam logic [63:0] HASH_K1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_K2 = 64'h94d049bb133111eb;
    localparam logic [63:0] CELL_KX = 64'h9e3779b185ebca87;
    localparam logic [63:0] CELL_KZ = 64'hc2b2ae3d27d4eb4f;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPREAD = 1'b0,
        REG_SEED   = 1'b1
    } cfg_reg_t;

    // Partial products of a 64 x 64 multiply kept modulo 2^64.
    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] mid_a;
        logic [31:0] mid_b;
    } mul_part_t;

    function automatic mul_part_t mul_split(input logic [63:0] a, input logic [63:0] k);
        logic [63:0] lo;
        logic [63:0] pa;
        logic [63:0] pb;
        lo = 64'(a[31:0]) * 64'(k[31:0]);
        pa = 64'(a[31:0]) * 64'(k[63:32]);
        pb = 64'(a[63:32]) * 64'(k[31:0]);
        return '{lo: lo, mid_a: pa[31:0], mid_b: pb[31:0]};
    endfunction

    function automatic logic [63:0] mul_join(input mul_part_t p);
        return {p.lo[63:32] + p.mid_a + p.mid_b, p.lo[31:0]};
    endfunction

endpackage

/* rtl/core/hashed_value_noise_2d.sv */
// Hashed 2D value noise: twelve register stages.
// Throughput: one word per cycle while noise_stall is low.
// The 64 x 64 hash multiplies are split into 32 x 32 partial products.
// Stalls ripple back only through full stages, so bubbles are squeezed out.
// Reset clears all stage valids, spread to zero (constant one half) and the seed.
module hashed_value_noise_2d
    import hvn_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 coord_valid,
    output logic                 coord_stall,
    input  logic [COORD_W-1:0]   u_coord,
    input  logic [COORD_W-1:0]   v_coord,
    output logic                 noise_valid,
    input  logic                 noise_stall,
    output logic [OUT_W-1:0]     noise_value
);

    localparam int FB     = COORD_FRAC_BITS + 16;
    localparam int CELL_W = (PROD_RAW_W > FB) ? PROD_RAW_W - FB : 1;
    localparam int PROD_W = FB + CELL_W;
    localparam int CIDX_W = CELL_W + 1;

    // Configuration
    logic [FREQ_W-1:0] freq_reg;
    logic [FREQ_W-1:0] freq_next;
    logic              spread_zero_reg;
    logic [CFG_W-1:0]  seed_reg;

    assign freq_next = FREQ_BASE + FREQ_W'(cfg_data[SPREAD_W-1:0]) * FREQ_SLOPE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg        <= FREQ_BASE;
            spread_zero_reg <= 1'b1;
            seed_reg        <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SPREAD:
                begin
                    freq_reg        <= freq_next;
                    spread_zero_reg <= (cfg_data[SPREAD_W-1:0] == '0);
                end
                REG_SEED:
                begin
                    seed_reg <= cfg_data;
                end
            endcase
        end
    end

    // Stage valids and advance chain
    logic [PIPE_DEPTH:1]   vld_reg;
    logic [PIPE_DEPTH:1]   vld_next;
    logic [PIPE_DEPTH+1:1] adv;

    assign vld_next = {vld_reg[PIPE_DEPTH-1:1], coord_valid};

    always_comb
    begin
        adv[PIPE_DEPTH+1] = !noise_stall;
        for (int i = PIPE_DEPTH; i >= 1; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= PIPE_DEPTH; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign coord_stall = !adv[1];
    assign noise_valid = vld_reg[PIPE_DEPTH];

    // Stage 1: scale both coordinates by the frequency
    logic [PROD_W-1:0] prod_reg [2];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            prod_reg[0] <= PROD_W'(u_coord) * PROD_W'(freq_reg);
            prod_reg[1] <= PROD_W'(v_coord) * PROD_W'(freq_reg);
        end
    end

    // Stage 2: split into cell and fraction, square the fraction
    logic [CIDX_W-1:0] cell0_reg [2];
    logic [CIDX_W-1:0] cell1_reg [2];
    logic [FRAC_W-1:0] frac_reg  [2];
    logic [FRAC_W-1:0] sq_reg    [2];
    logic [CELL_W-1:0] cell_w    [2];
    logic [FRAC_W-1:0] frac_w    [2];
    logic [31:0]       tsq_w     [2];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            cell_w[a] = prod_reg[a][PROD_W-1:FB];
            frac_w[a] = prod_reg[a][FB-1:FB-FRAC_W];
            tsq_w[a]  = 32'(frac_w[a]) * 32'(frac_w[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int a = 0; a < 2; a++)
            begin
                cell0_reg[a] <= CIDX_W'(cell_w[a]);
                cell1_reg[a] <= CIDX_W'(cell_w[a]) + CIDX_W'(1);
                frac_reg[a]  <= frac_w[a];
                sq_reg[a]    <= tsq_w[a][31:16];
            end
        end
    end

    // Stage 3: finish smoothstep, split the cell key multiplies
    logic [33:0]       wprod_w [2];
    logic [FRAC_W-1:0] wx_reg  [3:8];
    logic [FRAC_W-1:0] wz_reg  [3:10];
    mul_part_t         kpart_reg [4];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            wprod_w[a] = 34'(sq_reg[a]) * 34'(SMOOTH_THREE - 18'({frac_reg[a], 1'b0}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            wx_reg[3]    <= wprod_w[0][31:16];
            wz_reg[3]    <= wprod_w[1][31:16];
            kpart_reg[0] <= mul_split(64'(cell0_reg[0]), CELL_KX);
            kpart_reg[1] <= mul_split(64'(cell1_reg[0]), CELL_KX);
            kpart_reg[2] <= mul_split(64'(cell0_reg[1]), CELL_KZ);
            kpart_reg[3] <= mul_split(64'(cell1_reg[1]), CELL_KZ);
        end
        for (int i = 4; i <= 8; i++)
        begin
            if (adv[i])
            begin
                wx_reg[i] <= wx_reg[i-1];
            end
        end
        for (int i = 4; i <= 10; i++)
        begin
            if (adv[i])
            begin
                wz_reg[i] <= wz_reg[i-1];
            end
        end
    end

    // Stage 4: corner keys with the seed, first xor-shift
    // Corner order: (x0,z0), (x1,z0), (x0,z1), (x1,z1).
    logic [63:0] ckey_w [4];
    logic [63:0] kx_w   [2];
    logic [63:0] kz_w   [2];
    logic [63:0] h1_reg [4];

    always_comb
    begin
        kx_w[0] = mul_join(kpart_reg[0]);
        kx_w[1] = mul_join(kpart_reg[1]);
        kz_w[0] = mul_join(kpart_reg[2]);
        kz_w[1] = mul_join(kpart_reg[3]);
        for (int c = 0; c < 4; c++)
        begin
            ckey_w[c] = kx_w[c % 2] ^ kz_w[c / 2] ^ {32'b0, seed_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int c = 0; c < 4; c++)
            begin
                h1_reg[c] <= ckey_w[c] ^ (ckey_w[c] >> 30);
            end
        end
    end

    // Stages 5 to 8: the two finalizer multiplies, each split over two stages
    mul_part_t   p1_reg [4];
    mul_part_t   p2_reg [4];
    logic [63:0] h2_reg [4];
    logic [63:0] m1_w   [4];
    logic [63:0] m2_w   [4];
    logic [63:0] h3_w   [4];
    logic [CORNER_W-1:0] corner_reg [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            m1_w[c] = mul_join(p1_reg[c]);
            m2_w[c] = mul_join(p2_reg[c]);
            h3_w[c] = m2_w[c] ^ (m2_w[c] >> 31);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (adv[5])
            begin
                p1_reg[c] <= mul_split(h1_reg[c], HASH_K1);
            end
            if (adv[6])
            begin
                h2_reg[c] <= m1_w[c] ^ (m1_w[c] >> 27);
            end
            if (adv[7])
            begin
                p2_reg[c] <= mul_split(h2_reg[c], HASH_K2);
            end
            if (adv[8])
            begin
                corner_reg[c] <= h3_w[c][63:64-CORNER_W];
            end
        end
    end

    // Stages 9 to 12: bilinear blend
    logic [WGT_W-1:0] wx_hi_w;
    logic [WGT_W-1:0] wx_lo_w;
    logic [WGT_W-1:0] wz_hi_w;
    logic [WGT_W-1:0] wz_lo_w;
    logic [ROW_W-1:0] bprod_reg [4];
    logic [ROW_W-1:0] row_a_reg;
    logic [ROW_W-1:0] row_b_reg;
    logic [FIN_W-1:0] fin_a_reg;
    logic [FIN_W-1:0] fin_b_reg;
    logic [FIN_W-1:0] fin_sum_w;
    logic [OUT_W-1:0] out_reg;

    assign wx_hi_w   = WGT_W'(wx_reg[8]);
    assign wx_lo_w   = ONE_Q16 - wx_hi_w;
    assign wz_hi_w   = WGT_W'(wz_reg[10]);
    assign wz_lo_w   = ONE_Q16 - wz_hi_w;
    assign fin_sum_w = fin_a_reg + fin_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            bprod_reg[0] <= ROW_W'(corner_reg[0]) * ROW_W'(wx_lo_w);
            bprod_reg[1] <= ROW_W'(corner_reg[1]) * ROW_W'(wx_hi_w);
            bprod_reg[2] <= ROW_W'(corner_reg[2]) * ROW_W'(wx_lo_w);
            bprod_reg[3] <= ROW_W'(corner_reg[3]) * ROW_W'(wx_hi_w);
        end
        if (adv[10])
        begin
            row_a_reg <= bprod_reg[0] + bprod_reg[1];
            row_b_reg <= bprod_reg[2] + bprod_reg[3];
        end
        if (adv[11])
        begin
            fin_a_reg <= FIN_W'(row_a_reg) * FIN_W'(wz_lo_w);
            fin_b_reg <= FIN_W'(row_b_reg) * FIN_W'(wz_hi_w);
        end
        if (adv[12])
        begin
            out_reg <= spread_zero_reg ? HALF_OUT : fin_sum_w[32+OUT_W-1:32];
        end
    end

    assign noise_value = out_reg;

endmodule

/* rtl/core/hvn_check.sv */
// Port-level checker for the noise block, bound to the noise block module.
`include "hashed_value_noise_2d_assert.svh"

module hvn_check
    import hvn_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 coord_valid,
    input logic                 coord_stall,
    input logic                 noise_valid,
    input logic                 noise_stall,
    input logic [OUT_W-1:0]     noise_value
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             in_take;
    logic             out_take;

    assign in_take  = coord_valid && !coord_stall;
    assign out_take = noise_valid && !noise_stall;

    // Count words accepted and not yet delivered.
    assign inflight_next = inflight_reg + CNT_W'(in_take) - CNT_W'(out_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `HVN_ASSERT_NEXT(out_hold_a, noise_valid && noise_stall, noise_valid && $stable(noise_value))
    `HVN_ASSERT(out_has_source_a, noise_valid, inflight_reg != '0)
    `HVN_ASSERT(capacity_a, 1'b1, inflight_reg <= CNT_W'(PIPE_DEPTH))
    `HVN_ASSERT(empty_takes_a, inflight_reg == '0, !coord_stall)

endmodule

bind hashed_value_noise_2d hvn_check u_hvn_check (.*);

/* bench/tb.sv */
// Self-checking bench for the hashed value noise block, with a scoreboard and random stalls.
`timescale 1ns / 100ps

module tb
    import hvn_pkg::*;
();

    localparam int FRAC_SHIFT  = 16 + 16;     // coordinate fraction bits plus frequency bits
    localparam int CYCLE_LIMIT = 400000;

    // Predicts each noise word from the coordinates and holds the ones still owed.
    class noise_scoreboard;
        logic [23:0] owed_noise[$];
        logic [16:0] spread_q;
        logic [31:0] seed_q;
        int          errors;

        function new();
            spread_q = '0;
            seed_q   = '0;
            errors   = 0;
        endfunction

        function void set_regs(logic [16:0] spr, logic [31:0] sd);
            spread_q = spr;
            seed_q   = sd;
        endfunction

        function logic [63:0] mix64(logic [63:0] h);
            h = (h ^ (h >> 30)) * HASH_K1;
            h = (h ^ (h >> 27)) * HASH_K2;
            return h ^ (h >> 31);
        endfunction

        function logic [63:0] corner_at(logic [63:0] cx, logic [63:0] cz);
            logic [63:0] key;
            key = (cx * CELL_KX) ^ (cz * CELL_KZ) ^ {32'h0, seed_q};
            return mix64(key) >> 40;
        endfunction

        function logic [63:0] ease_q16(logic [15:0] t);
            logic [63:0] tt;
            logic [63:0] s2;
            tt = 64'(t);
            s2 = (tt * tt) >> 16;
            return (s2 * (64'd196608 - 64'd2 * tt)) >> 16;
        endfunction

        function logic [23:0] noise_at(logic [15:0] u, logic [15:0] v);
            logic [63:0] freq;
            logic [63:0] pu;
            logic [63:0] pv;
            logic [63:0] x0;
            logic [63:0] z0;
            logic [63:0] wx;
            logic [63:0] wz;
            logic [63:0] row_a;
            logic [63:0] row_b;
            logic [63:0] blend;
            if (spread_q == '0)
                return HALF_OUT;
            freq  = 64'd65536 + 64'd31 * 64'(spread_q);
            pu    = 64'(u) * freq;
            pv    = 64'(v) * freq;
            x0    = pu >> FRAC_SHIFT;
            z0    = pv >> FRAC_SHIFT;
            wx    = ease_q16(pu[FRAC_SHIFT-1 -: 16]);
            wz    = ease_q16(pv[FRAC_SHIFT-1 -: 16]);
            row_a = corner_at(x0, z0) * (64'd65536 - wx) + corner_at(x0 + 64'd1, z0) * wx;
            row_b = corner_at(x0, z0 + 64'd1) * (64'd65536 - wx)
                  + corner_at(x0 + 64'd1, z0 + 64'd1) * wx;
            blend = (row_a * (64'd65536 - wz) + row_b * wz) >> 32;
            return blend[23:0];
        endfunction

        function void note_coord(logic [15:0] u, logic [15:0] v);
            owed_noise.push_back(noise_at(u, v));
        endfunction

        function void check_noise(logic [23:0] got);
            logic [23:0] want;
            if (owed_noise.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("noise word with nothing pending: got %h", got);
                return;
            end
            want = owed_noise.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("noise_value mismatch: expected %h got %h", want, got);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 coord_valid;
    logic                 coord_stall;
    logic [COORD_W-1:0]   u_coord;
    logic [COORD_W-1:0]   v_coord;
    logic                 noise_valid;
    logic                 noise_stall;
    logic [OUT_W-1:0]     noise_value;

    noise_scoreboard sb;
    int              coords_taken;
    int              cycle_count;
    bit              no_idle;

    hashed_value_noise_2d dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .coord_valid (coord_valid),
        .coord_stall (coord_stall),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .noise_valid (noise_valid),
        .noise_stall (noise_stall),
        .noise_value (noise_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_coord(logic [15:0] u, logic [15:0] v);
        while (!no_idle && $urandom_range(0, 99) < 27)
        begin
            coord_valid <= 1'b0;
            @(negedge clk);
        end
        coord_valid <= 1'b1;
        u_coord     <= u;
        v_coord     <= v;
        do
            @(posedge clk);
        while (coord_stall);
        sb.note_coord(u, v);
        coords_taken++;
        @(negedge clk);
    endtask

    // Write both registers while the pipeline is empty.
    task automatic load_config(logic [16:0] spr, logic [31:0] sd);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SPREAD;
        cfg_data  <= 32'(spr);
        @(negedge clk);
        cfg_index <= REG_SEED;
        cfg_data  <= sd;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        sb.set_regs(spr, sd);
    endtask

    task automatic wait_drained();
        coord_valid <= 1'b0;
        while (sb.owed_noise.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    initial
    begin
        logic [16:0] spr;
        logic [31:0] sd;
        sb          = new();
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_SPREAD;
        cfg_data    = '0;
        coord_valid = 1'b0;
        u_coord     = '0;
        v_coord     = '0;
        no_idle     = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero spread gives constant one half.
        send_coord(16'h0000, 16'h0000);
        send_coord(16'hffff, 16'hffff);

        wait_drained();
        load_config(17'd65536, 32'h7fffffff);
        send_coord(16'h0000, 16'h0000);
        send_coord(16'hffff, 16'hffff);
        send_coord(16'hffff, 16'h0000);
        send_coord(16'h0000, 16'hffff);
        send_coord(16'h8000, 16'h8000);
        send_coord(16'h0001, 16'hfffe);

        // Spread beyond 1.0 with the most negative seed.
        wait_drained();
        load_config(17'h1ffff, 32'h80000000);
        send_coord(16'h0000, 16'h0000);
        send_coord(16'hffff, 16'hffff);
        send_coord(16'h7fff, 16'h8001);
        send_coord(16'haaaa, 16'h5555);
        send_coord(16'h5555, 16'haaaa);

        wait_drained();
        load_config(17'd1, 32'hffffffff);
        send_coord(16'hffff, 16'hffff);
        send_coord(16'h0000, 16'h0001);
        send_coord(16'h1234, 16'hfedc);

        // Zero spread must ignore the seed.
        wait_drained();
        load_config(17'd0, 32'h12345678);
        send_coord(16'hffff, 16'h0000);
        send_coord(16'h8000, 16'hffff);

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:
                begin
                    spr = 17'd65536;
                    sd  = $urandom();
                end
                1:
                begin
                    spr = 17'h1ffff;
                    sd  = 32'h00000000;
                end
                2:
                begin
                    spr = 17'd1;
                    sd  = 32'h80000000;
                end
                3:
                begin
                    spr = 17'($urandom_range(1, 131071));
                    sd  = $urandom();
                end
                4:
                begin
                    spr = 17'($urandom_range(1, 2048));
                    sd  = 32'hffffffff;
                end
                5:
                begin
                    spr = 17'd0;
                    sd  = $urandom();
                end
                default:
                begin
                    spr = 17'($urandom_range(0, 131071));
                    sd  = 32'h7fffffff;
                end
            endcase
            wait_drained();
            load_config(spr, sd);
            no_idle = (ph == 3);
            repeat (150) send_coord(pick_coord(), pick_coord());
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (8) @(negedge clk);
        if (sb.errors == 0 && sb.owed_noise.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Output side: random stall, plus one long hold-off mid-run to back up the pipeline.
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left   = 0;
        hold_done   = 1'b0;
        noise_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && coords_taken >= 500)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                noise_stall <= 1'b1;
            end
            else
                noise_stall <= !no_idle && ($urandom_range(0, 99) < 27);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && noise_valid && !noise_stall)
            sb.check_noise(noise_value);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/hvn_pkg.sv
rtl/core/hashed_value_noise_2d.sv
rtl/core/hvn_check.sv
bench/tb.sv
